// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock and idle during reset
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clock and idle during reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/csq_pkg.sv =====
`default_nettype none

package csq_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int KIND_BITS     = 4;
   localparam int VALUE_BITS    = 32;
   localparam int POSITION_BITS = 6;
   localparam int COUNT_BITS    = 7;
   localparam int ERROR_BITS    = 2;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_START        = 4'd0,
      KIND_END          = 4'd1,
      KIND_ADVANCE      = 4'd2,
      KIND_RETREAT      = 4'd3,
      KIND_INSERT       = 4'd4,
      KIND_ATTACH       = 4'd5,
      KIND_REMOVE       = 4'd6,
      KIND_INSERT_FRONT = 4'd7,
      KIND_ATTACH_BACK  = 4'd8,
      KIND_REMOVE_FRONT = 4'd9,
      KIND_READ_AT      = 4'd10,
      KIND_QUERY        = 4'd11
   } kind_type;

   typedef enum logic [ERROR_BITS-1:0] {
      ERR_OK         = 2'd0,
      ERR_FULL       = 2'd1,
      ERR_NO_CURRENT = 2'd2,
      ERR_RANGE      = 2'd3
   } error_type;

   // what every cell of the chain does at the next edge
   typedef enum logic [1:0] {
      SHIFT_HOLD  = 2'd0,
      SHIFT_OPEN  = 2'd1,
      SHIFT_CLOSE = 2'd2
   } shift_op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_REDUCE = 2'd1,
      ST_REPLY  = 2'd2
   } state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [VALUE_BITS-1:0]    entry_value;
      logic [POSITION_BITS-1:0] position;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] read_value;
      logic [COUNT_BITS-1:0] item_count;
      logic [COUNT_BITS-1:0] cursor_pos;
      logic                  has_current;
      logic [ERROR_BITS-1:0] error_code;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/cursor_sequence_store_top.sv =====
`default_nettype none

// ordered store of up to DEPTH words with a cursor on the current entry
// req channel: one item per operation (kind, entry_value, position), taken
//   on a rising edge with req_valid high and req_stall low
// rsp channel: exactly one item per request, in order: read_value,
//   item_count, cursor_pos, has_current, error_code after the operation
// the entries live in a chain of cells; an insert opens a gap and a remove
//   closes it when the item is taken, the cells from the edit point up shifting at once
// read_value comes from a registered or-tree over the cells, one level per
//   cycle; the sequencer waits in its reduce state until the tree has settled,
//   then offers the response; a new item can be taken in the cycle after the
//   response is taken
// one item is in flight at a time: req_stall is high from acceptance until
//   the response leaves
// while rsp_stall is high the response item holds and no request is taken
// reset empties the store and sets the cursor to zero; entry words are not
//   cleared, only positions below the count are ever shown
// a failed operation reports its error code and leaves the store untouched

module cursor_sequence_store_top
   import csq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POSITION_BITS) ? CNT_W : POSITION_BITS;
   localparam int LEVELS = $clog2(DEPTH);
   localparam int LAT_W  = $clog2(LEVELS + 1);

   // control state
   state_type        state_ff, state_in;
   logic [LAT_W-1:0] lat_ff, lat_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;

   // per-item payload kept for the response
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic             rd_en_ff, rd_en_in;
   error_type        err_ff, err_in;

   logic load;

   // result of decoding the request
   logic [CNT_W-1:0]     step_count;
   logic [CNT_W-1:0]     step_cursor;
   logic [CNT_W-1:0]     step_at;
   shift_op_type         step_op;
   error_type            step_err;
   logic                 step_read;
   logic                 has_cur;
   logic                 is_full;
   logic                 pos_ok;

   // chain wiring
   shift_op_type         cell_op;
   logic [IDX_W-1:0]     cell_at;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] chain_word [DEPTH];
   logic [WORD_BITS-1:0] leaf_word  [DEPTH];
   logic [WORD_BITS-1:0] tree_root;

   assign load = req_valid && !req_stall;

   // operation decode against the current count and cursor
   always_comb begin
      has_cur     = cursor_ff < count_ff;
      is_full     = count_ff == CNT_W'(DEPTH);
      pos_ok      = CMP_W'(req_item.position) < CMP_W'(count_ff);
      step_count  = count_ff;
      step_cursor = cursor_ff;
      step_at     = '0;
      step_op     = SHIFT_HOLD;
      step_err    = ERR_OK;
      step_read   = 1'b0;
      unique case (req_item.kind)
         KIND_START: begin
            step_cursor = '0;
         end
         KIND_END: begin
            step_cursor = (count_ff == '0) ? '0 : count_ff - 1'b1;
         end
         KIND_ADVANCE: begin
            if (has_cur) begin
               step_cursor = cursor_ff + 1'b1;
            end else begin
               step_err = ERR_NO_CURRENT;
            end
         end
         KIND_RETREAT: begin
            if (cursor_ff != '0) begin
               step_cursor = cursor_ff - 1'b1;
            end
         end
         KIND_INSERT: begin
            if (is_full) begin
               step_err = ERR_FULL;
            end else begin
               step_at     = has_cur ? cursor_ff : '0;
               step_cursor = step_at;
               step_op     = SHIFT_OPEN;
               step_count  = count_ff + 1'b1;
            end
         end
         KIND_ATTACH: begin
            if (is_full) begin
               step_err = ERR_FULL;
            end else begin
               step_at     = has_cur ? cursor_ff + 1'b1 : count_ff;
               step_cursor = step_at;
               step_op     = SHIFT_OPEN;
               step_count  = count_ff + 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (!has_cur) begin
               step_err = ERR_NO_CURRENT;
            end else begin
               step_at    = cursor_ff;
               step_op    = SHIFT_CLOSE;
               step_count = count_ff - 1'b1;
            end
         end
         KIND_INSERT_FRONT: begin
            if (is_full) begin
               step_err = ERR_FULL;
            end else begin
               step_cursor = '0;
               step_op     = SHIFT_OPEN;
               step_count  = count_ff + 1'b1;
            end
         end
         KIND_ATTACH_BACK: begin
            if (is_full) begin
               step_err = ERR_FULL;
            end else begin
               step_at     = count_ff;
               step_cursor = count_ff;
               step_op     = SHIFT_OPEN;
               step_count  = count_ff + 1'b1;
            end
         end
         KIND_REMOVE_FRONT: begin
            if (count_ff == '0) begin
               step_err = ERR_NO_CURRENT;
            end else begin
               step_cursor = '0;
               step_op     = SHIFT_CLOSE;
               step_count  = count_ff - 1'b1;
            end
         end
         KIND_READ_AT: begin
            step_read = 1'b1;
            if (!pos_ok) begin
               step_err = ERR_RANGE;
            end
         end
         default: begin
            // query and the unused kinds leave everything as it is
            step_op = SHIFT_HOLD;
         end
      endcase
   end

   // next values of the stored state
   always_comb begin
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      rd_addr_in = rd_addr_ff;
      rd_en_in   = rd_en_ff;
      err_in     = err_ff;
      if (load) begin
         count_in  = step_count;
         cursor_in = step_cursor;
         err_in    = step_err;
         if (step_read) begin
            rd_addr_in = IDX_W'(req_item.position);
            rd_en_in   = step_err == ERR_OK;
         end else begin
            rd_addr_in = IDX_W'(step_cursor);
            rd_en_in   = step_cursor < step_count;
         end
      end
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      lat_in   = lat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_REDUCE;
               lat_in   = LAT_W'(LEVELS);
            end
         end
         ST_REDUCE: begin
            lat_in = lat_ff - 1'b1;
            if (lat_ff == LAT_W'(1)) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_REPLY:  rsp_valid = 1'b1;
         default:   req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         lat_ff    <= '0;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         lat_ff    <= lat_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_en_ff   <= rd_en_in;
      err_ff     <= err_in;
   end

   // broadcast to the chain, the cells hold unless an item is taken
   assign cell_op  = load ? step_op : SHIFT_HOLD;
   assign cell_at  = IDX_W'(step_at);
   assign new_word = WORD_BITS'(req_item.entry_value);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = chain_word[i-1];
      end

      // the last cell's word falls outside the count after a close
      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = chain_word[i+1];
      end

      csq_cell #(
         .WORD_BITS (WORD_BITS),
         .IDX_W     (IDX_W),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .at_addr    (cell_at),
         .rd_addr    (rd_addr_ff),
         .rd_en      (rd_en_ff),
         .new_word   (new_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word_out   (chain_word[i]),
         .leaf_out   (leaf_word[i])
      );
   end

   // selected word travels up the or-tree; no selection gives zero
   csq_read_tree #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_read_tree (
      .clock (clock),
      .leaf  (leaf_word),
      .root  (tree_root)
   );

   // response fields straight from the stored state after the step
   always_comb begin
      rsp_item.read_value  = VALUE_BITS'(tree_root);
      rsp_item.item_count  = COUNT_BITS'(count_ff);
      rsp_item.cursor_pos  = COUNT_BITS'(cursor_ff);
      rsp_item.has_current = cursor_ff < count_ff;
      rsp_item.error_code  = err_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/csq_cell.sv =====
`default_nettype none

module csq_cell
   import csq_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   parameter int IDX_W     = 6,
   parameter int INDEX     = 0
) (
   input  wire logic                 clock,
   input  wire shift_op_type         op,
   input  wire logic [IDX_W-1:0]     at_addr,
   input  wire logic [IDX_W-1:0]     rd_addr,
   input  wire logic                 rd_en,
   input  wire logic [WORD_BITS-1:0] new_word,
   input  wire logic [WORD_BITS-1:0] left_word,
   input  wire logic [WORD_BITS-1:0] right_word,
   output logic      [WORD_BITS-1:0] word_out,
   output logic      [WORD_BITS-1:0] leaf_out
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (op)
         SHIFT_OPEN: begin
            if (MY_INDEX > at_addr) begin
               word_in = left_word;
            end else if (MY_INDEX == at_addr) begin
               word_in = new_word;
            end
         end
         SHIFT_CLOSE: begin
            if (MY_INDEX >= at_addr) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
   assign leaf_out = (rd_en && (rd_addr == MY_INDEX)) ? word_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/csq_read_tree.sv =====
`default_nettype none

module csq_read_tree
   import csq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic [WORD_BITS-1:0] leaf [DEPTH],
   output logic      [WORD_BITS-1:0] root
);

   localparam int LEVELS = $clog2(DEPTH);
   localparam int PAD    = 1 << LEVELS;
   localparam int HALF   = PAD / 2;

   logic [WORD_BITS-1:0] leaf_pad [PAD];
   logic [WORD_BITS-1:0] node_ff  [1:PAD-1];

   // leaves past the last cell read as zero
   for (genvar i = 0; i < PAD; i++) begin : g_pad
      if (i < DEPTH) begin : g_real
         assign leaf_pad[i] = leaf[i];
      end else begin : g_zero
         assign leaf_pad[i] = '0;
      end
   end

   // heap layout, node n has children 2n and 2n+1; one level per cycle
   always_ff @(posedge clock) begin
      for (int n = 1; n < PAD; n++) begin
         if (n >= HALF) begin
            node_ff[n] <= leaf_pad[2*n-PAD] | leaf_pad[2*n+1-PAD];
         end else begin
            node_ff[n] <= node_ff[2*n] | node_ff[2*n+1];
         end
      end
   end

   assign root = node_ff[1];

endmodule

`default_nettype wire

// ===== rtl/csq_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module csq_checker
   import csq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_item
);

   logic [COUNT_BITS-1:0] last_count_ff;
   logic [COUNT_BITS-1:0] last_count_in;
   logic                  req_take;
   logic                  rsp_take;

   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;

   assign last_count_in = rsp_take ? rsp_item.item_count : last_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else begin
         last_count_ff <= last_count_in;
      end
   end

   // a waiting response item holds still
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // no new request while a response is pending
   `ASSERT_IMPLY(a_one_in_flight, rsp_valid, req_stall)

   // the response never comes in the cycle after acceptance
   `ASSERT_NEXT(a_min_latency, req_take, !rsp_valid)

   // the count moves by at most one entry per item
   `ASSERT_IMPLY(a_count_step, rsp_valid,
      (rsp_item.item_count == last_count_ff) ||
      (rsp_item.item_count == COUNT_BITS'(last_count_ff + 1'b1)) ||
      (rsp_item.item_count == COUNT_BITS'(last_count_ff - 1'b1)))

   // a failed operation leaves the count untouched
   `ASSERT_IMPLY(a_error_no_change, rsp_valid && (rsp_item.error_code != ERR_OK),
      rsp_item.item_count == last_count_ff)

endmodule

bind cursor_sequence_store_top csq_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// cursor store testbench: directed items on an empty and a small store, a
// fill to the full store and back, a long reply hold-off, then random
// sequences of edits biased to grow, shrink or hold the store
module tb_top;
   import csq_pkg::*;

   // kinds 12 to 15 have no operation and only report the state
   localparam logic [KIND_BITS-1:0] KIND_UNUSED_FIRST = 4'd12;
   localparam logic [KIND_BITS-1:0] KIND_UNUSED_LAST  = 4'd15;

   localparam int unsigned HOLD_OFF_CYCLES = 200;
   localparam int unsigned PRESSURE_ITEMS  = 16;
   localparam int unsigned RANDOM_SEGMENTS = 26;
   localparam int unsigned SEGMENT_ITEMS   = 50;
   localparam int unsigned DRAIN_CYCLES    = 20;
   // longest quiet spell is the hold-off plus one item through the block
   localparam int unsigned WATCHDOG_LIMIT  = 2000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   // predicted copy of the store, updated as each item is taken
   logic [VALUE_BITS-1:0] store_words [DEPTH_DEFAULT];
   int unsigned           store_count  = 0;
   int unsigned           store_cursor = 0;

   // predicted replies, oldest first
   rsp_type predicted_snapshots [$];

   int unsigned fault_count     = 0;
   int unsigned idle_cycles     = 0;
   bit          no_gaps         = 1'b0;
   bit          hold_off_request = 1'b0;
   bit          stall_level     = 1'b0;
   int unsigned stall_left      = 0;

   always #5 clock = ~clock;

   cursor_sequence_store_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // shift everything from index at upwards and put the word in the gap
   function automatic void open_gap(int unsigned at, logic [VALUE_BITS-1:0] word);
      int unsigned i;
      for (i = store_count; i > at; i--) store_words[i] = store_words[i-1];
      store_words[at] = word;
      store_count++;
   endfunction

   // drop the entry at index at and pull the rest down
   function automatic void close_gap(int unsigned at);
      int unsigned i;
      for (i = at; i + 1 < store_count; i++) store_words[i] = store_words[i+1];
      store_count--;
   endfunction

   // carries out one operation on the predicted store and returns the reply
   function automatic rsp_type apply_operation(req_type op);
      rsp_type               snap;
      logic                  had_current;
      logic                  full;
      logic                  is_read;
      error_type             fault;
      logic [VALUE_BITS-1:0] shown;
      full        = (store_count >= DEPTH_DEFAULT);
      had_current = (store_cursor < store_count);
      fault       = ERR_OK;
      is_read     = 1'b0;
      shown       = '0;
      case (op.kind)
         KIND_START: store_cursor = 0;
         KIND_END: store_cursor = (store_count == 0) ? 0 : store_count - 1;
         KIND_ADVANCE: begin
            if (had_current) store_cursor++;
            else fault = ERR_NO_CURRENT;
         end
         KIND_RETREAT: begin
            // retreat at the front is quietly ignored
            if (store_cursor > 0) store_cursor--;
         end
         KIND_INSERT: begin
            if (full) begin
               fault = ERR_FULL;
            end else begin
               if (!had_current) store_cursor = 0;
               open_gap(store_cursor, op.entry_value);
            end
         end
         KIND_ATTACH: begin
            if (full) begin
               fault = ERR_FULL;
            end else begin
               store_cursor = had_current ? store_cursor + 1 : store_count;
               open_gap(store_cursor, op.entry_value);
            end
         end
         KIND_REMOVE: begin
            if (!had_current) fault = ERR_NO_CURRENT;
            else close_gap(store_cursor);
         end
         KIND_INSERT_FRONT: begin
            if (full) begin
               fault = ERR_FULL;
            end else begin
               store_cursor = 0;
               open_gap(0, op.entry_value);
            end
         end
         KIND_ATTACH_BACK: begin
            if (full) begin
               fault = ERR_FULL;
            end else begin
               store_cursor = store_count;
               open_gap(store_cursor, op.entry_value);
            end
         end
         KIND_REMOVE_FRONT: begin
            if (store_count == 0) begin
               fault = ERR_NO_CURRENT;
            end else begin
               store_cursor = 0;
               close_gap(0);
            end
         end
         KIND_READ_AT: begin
            is_read = 1'b1;
            if (op.position < store_count) shown = store_words[op.position];
            else fault = ERR_RANGE;
         end
         default: ;
      endcase
      if (!is_read && store_cursor < store_count) shown = store_words[store_cursor];
      snap.read_value  = shown;
      snap.item_count  = COUNT_BITS'(store_count);
      snap.cursor_pos  = COUNT_BITS'(store_cursor);
      snap.has_current = (store_cursor < store_count);
      snap.error_code  = fault;
      return snap;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_word();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [KIND_BITS-1:0] pick_growth_kind();
      case ($urandom_range(0, 3))
         0: return KIND_INSERT;
         1: return KIND_ATTACH;
         2: return KIND_INSERT_FRONT;
         default: return KIND_ATTACH_BACK;
      endcase
   endfunction

   // offers one item from a falling edge, waits until it is taken, then may
   // leave a gap; returns on a falling edge with the predictor up to date
   task automatic send_op(input logic [KIND_BITS-1:0] kind,
                          input logic [VALUE_BITS-1:0] value,
                          input logic [POSITION_BITS-1:0] position);
      req_type     op;
      int unsigned gap;
      op.kind        = kind;
      op.entry_value = value;
      op.position    = position;
      req_item  <= op;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted_snapshots.push_back(apply_operation(op));
      gap = no_gaps ? 0 : pick_idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // every operation but the insertions on an empty store; advance, remove and read fail
   task automatic test_empty_store();
      send_op(KIND_QUERY, '0, '0);
      send_op(KIND_START, '0, '0);
      send_op(KIND_END, '0, '0);          // end on an empty store gives cursor 0
      send_op(KIND_ADVANCE, '0, '0);      // no current item
      send_op(KIND_RETREAT, '0, '0);      // at the front, cursor stays, no error
      send_op(KIND_REMOVE, '0, '0);
      send_op(KIND_REMOVE_FRONT, '0, '0);
      send_op(KIND_READ_AT, '0, '0);      // out of range
      send_op(KIND_UNUSED_LAST, '1, '1);
      send_op(KIND_UNUSED_FIRST, '0, '0);
   endtask

   // edits around the cursor, with and without a current item
   task automatic test_cursor_edits();
      send_op(KIND_INSERT, '0, '0);               // no current, goes to the front
      send_op(KIND_ATTACH, '1, '1);               // after the current one
      send_op(KIND_INSERT_FRONT, 32'haaaa_aaaa, '0);
      send_op(KIND_ATTACH_BACK, 32'h5555_5555, '0);
      send_op(KIND_ADVANCE, '0, '0);              // walks off the end
      send_op(KIND_ATTACH, 32'h1234_5678, '0);    // no current, goes to the back
      send_op(KIND_ADVANCE, '0, '0);
      send_op(KIND_INSERT, 32'h9abc_def0, '0);    // no current, goes to the front
      send_op(KIND_END, '0, '0);
      send_op(KIND_RETREAT, '0, '0);
      send_op(KIND_REMOVE, '0, '0);               // middle entry, gap closes
      send_op(KIND_READ_AT, '0, '0);
      send_op(KIND_READ_AT, '0, POSITION_BITS'(store_count - 1));
      send_op(KIND_READ_AT, '0, POSITION_BITS'(store_count)); // one past the end
      send_op(KIND_READ_AT, '0, '1);
      send_op(KIND_START, '0, '0);
      send_op(KIND_REMOVE, '0, '0);
      send_op(KIND_REMOVE_FRONT, '0, '0);
      send_op(KIND_QUERY, '0, '0);
   endtask

   // fill to the limit, try every insertion on the full store, then empty it
   task automatic test_full_store();
      while (store_count < DEPTH_DEFAULT)
         send_op(pick_growth_kind(), random_word(), POSITION_BITS'($urandom));
      send_op(KIND_INSERT, random_word(), '0);
      send_op(KIND_ATTACH, random_word(), '0);
      send_op(KIND_INSERT_FRONT, random_word(), '0);
      send_op(KIND_ATTACH_BACK, random_word(), '0);
      send_op(KIND_READ_AT, '0, POSITION_BITS'(DEPTH_DEFAULT - 1));
      send_op(KIND_END, '0, '0);
      send_op(KIND_ADVANCE, '0, '0);              // cursor equals count now
      send_op(KIND_ATTACH, random_word(), '0);    // full with no current item
      send_op(KIND_QUERY, '0, '0);
      while (store_count > 0) begin
         if (store_cursor < store_count && $urandom_range(0, 1) == 1)
            send_op(KIND_REMOVE, '0, '0);
         else
            send_op(KIND_REMOVE_FRONT, '0, '0);
      end
   endtask

   // replies are held back for a long spell while items keep coming
   // back to back, so the block, with its one item waiting, holds its input off
   task automatic test_receiver_hold_off();
      int unsigned n;
      hold_off_request = 1'b1;
      no_gaps          = 1'b1;
      for (n = 0; n < PRESSURE_ITEMS; n++) begin
         if (n % 2 == 0) send_op(pick_growth_kind(), random_word(), '0);
         else send_op(KIND_READ_AT, '0, POSITION_BITS'($urandom_range(0, 7)));
      end
      no_gaps = 1'b0;
   endtask

   // segments that lean towards growing, shrinking or holding the store,
   // some of them with items offered back to back
   task automatic test_random_sequences();
      int unsigned           segment;
      int unsigned           n;
      int unsigned           grow_pct;
      int unsigned           shrink_pct;
      int unsigned           roll;
      logic [KIND_BITS-1:0]  kind;
      logic [POSITION_BITS-1:0] position;
      for (segment = 0; segment < RANDOM_SEGMENTS; segment++) begin
         case ($urandom_range(0, 2))
            0: begin
               grow_pct   = 60;
               shrink_pct = 10;
            end
            1: begin
               grow_pct   = 15;
               shrink_pct = 55;
            end
            default: begin
               grow_pct   = 30;
               shrink_pct = 25;
            end
         endcase
         no_gaps = ($urandom_range(0, 4) == 0);
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < grow_pct) begin
               kind = pick_growth_kind();
            end else if (roll < grow_pct + shrink_pct) begin
               kind = ($urandom_range(0, 2) == 0) ? KIND_REMOVE_FRONT : KIND_REMOVE;
            end else if (roll < 88) begin
               case ($urandom_range(0, 3))
                  0: kind = KIND_START;
                  1: kind = KIND_END;
                  2: kind = KIND_ADVANCE;
                  default: kind = KIND_RETREAT;
               endcase
            end else if (roll < 97) begin
               kind = KIND_READ_AT;
            end else if (roll < 98) begin
               kind = KIND_QUERY;
            end else begin
               kind = KIND_BITS'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
            end
            // mostly a stored index, sometimes anything at all
            if ($urandom_range(0, 3) == 0 || store_count == 0)
               position = POSITION_BITS'($urandom);
            else
               position = POSITION_BITS'($urandom_range(0, store_count - 1));
            send_op(kind, random_word(), position);
         end
      end
      no_gaps = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // reply side
   // ---------------------------------------------------------------------

   // reply stall alternates between free runs and stalls; a hold-off
   // request overrides whatever run is in progress
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         stall_level      = 1'b1;
         stall_left       = HOLD_OFF_CYCLES;
      end else if (stall_left == 0) begin
         stall_level = !stall_level;
         if (stall_level) stall_left = pick_idle_length() + 1;
         else if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(100, 200);
         else stall_left = $urandom_range(1, 30);
      end
      rsp_stall <= stall_level;
      stall_left--;
   end

   function automatic void check_field(string name, logic [VALUE_BITS-1:0] want,
                                       logic [VALUE_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         fault_count++;
      end
   endfunction

   // every reply taken is matched against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_snapshots.size() == 0) begin
            $display("%0t: reply with none expected, expected nothing, got %p",
                     $time, rsp_item);
            fault_count++;
         end else begin
            want = predicted_snapshots.pop_front();
            check_field("read_value", want.read_value, rsp_item.read_value);
            check_field("item_count", VALUE_BITS'(want.item_count),
                        VALUE_BITS'(rsp_item.item_count));
            check_field("cursor_pos", VALUE_BITS'(want.cursor_pos),
                        VALUE_BITS'(rsp_item.cursor_pos));
            check_field("has_current", VALUE_BITS'(want.has_current),
                        VALUE_BITS'(rsp_item.has_current));
            check_field("error_code", VALUE_BITS'(want.error_code),
                        VALUE_BITS'(rsp_item.error_code));
         end
      end
   end

   // ends the run if neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_cursor_edits();
      test_full_store();
      test_receiver_hold_off();
      test_random_sequences();
      // last item offered is taken by now; drop valid and let replies drain
      req_valid <= 1'b0;
      while (predicted_snapshots.size() != 0) @(posedge clock);
      // catch any stray reply after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
